// ===== hw/rtl/wsd_pkg.sv =====
// Shared constants, types and the tap table of the windowed-sinc decimator.
`default_nettype none
package wsd_pkg;

	localparam int DECIM_RATIO     = 4;
	localparam int HALF_TAPS       = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int HIST_LEN  = 2 * HALF_TAPS - 1;
	localparam int AGE_W     = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int MEM_DEPTH = 2 ** AGE_W;
	localparam int FILL_W    = $clog2(HIST_LEN + 1);
	localparam int TAP_W     = (HALF_TAPS > 1) ? $clog2(HALF_TAPS) : 1;
	localparam int PHASE_W   = (DECIM_RATIO > 1) ? $clog2(DECIM_RATIO) : 1;

	localparam int COEF_W    = 19;
	localparam int COEF_FRAC = 17;

	localparam int WARM_W     = 17;
	localparam int COUNT_W    = 16;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;

	localparam longint ONE_Q28  = 64'sd268435456;
	localparam longint PI_Q28   = 64'sd843314857;
	localparam longint COEF_ONE = 64'sd131072;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_tab_t [HALF_TAPS];

	typedef struct packed {
		logic             vld;
		logic             last;
		logic [TAP_W-1:0] tap;
	} iter_t;

	// Truncating signed division by shift and subtract.
	function automatic longint div_trunc(longint num_in, longint den_in);
		longint mag_n, mag_d, quo, rem;
		bit     neg_q;
		neg_q = (num_in < 0) != (den_in < 0);
		mag_n = (num_in < 0) ? -num_in : num_in;
		mag_d = (den_in < 0) ? -den_in : den_in;
		quo = 0;
		rem = 0;
		for (int b = 62; b >= 0; b--) begin
			rem = (rem <<< 1) | longint'(mag_n[b]);
			if (rem >= mag_d) begin
				rem = rem - mag_d;
				quo[b] = 1'b1;
			end
		end
		return neg_q ? -quo : quo;
	endfunction

	// Hann-windowed sinc, unit DC gain, Q1.17; evaluated at elaboration only.
	function automatic coef_tab_t build_taps();
		longint    raw [HALF_TAPS];
		longint    sv [2];
		longint    s, num, c, p, q, x, x2, term, sum, sn, win;
		bit        neg;
		coef_tab_t tab;
		for (int i = 0; i < HALF_TAPS; i++) begin
			for (int w = 0; w < 2; w++) begin
				if (w == 0) begin
					p = longint'(i);
					q = longint'(DECIM_RATIO);
				end else begin
					p = 2 * longint'(i) + longint'(HALF_TAPS);
					q = 2 * longint'(HALF_TAPS);
				end
				neg = 1'b0;
				p = p - div_trunc(p, 2 * q) * (2 * q);
				if (p >= q) begin
					p = p - q;
					neg = 1'b1;
				end
				if (2 * p > q) p = q - p;
				x = div_trunc(PI_Q28 * p, q);
				x2 = div_trunc(x * x, ONE_Q28);
				term = x;
				sum = x;
				for (int n = 1; n <= 7; n++) begin
					term = div_trunc(-div_trunc(term * x2, ONE_Q28),
						longint'((2 * n) * (2 * n + 1)));
					sum = sum + term;
				end
				sv[w] = neg ? -sum : sum;
			end
			if (i == 0) sn = ONE_Q28;
			else sn = div_trunc(sv[0] * longint'(DECIM_RATIO) * ONE_Q28,
				PI_Q28 * longint'(i));
			win = ONE_Q28 + sv[1];
			raw[i] = div_trunc(sn * win, ONE_Q28);
		end
		s = raw[0];
		for (int i = 1; i < HALF_TAPS; i++) s = s + 2 * raw[i];
		if (s <= 0) s = 1;
		for (int i = 0; i < HALF_TAPS; i++) begin
			num = raw[i] * COEF_ONE;
			if (num >= 0) c = div_trunc(num + div_trunc(s, 2), s);
			else c = -div_trunc(-num + div_trunc(s, 2), s);
			tab[i] = c[COEF_W-1:0];
		end
		return tab;
	endfunction

	localparam coef_tab_t COEF_TAB = build_taps();

endpackage
`default_nettype wire

// ===== hw/rtl/windowed_sinc_decimator.sv =====
// Windowed-sinc decimator top level: sequencer, configuration and output register.
//
// Input channel (in_valid / in_stall, sample, beyond_end): one word per audio sample;
// beyond_end forces the word to zero. The block decimates by DECIM_RATIO through a
// symmetric FIR of 2*HALF_TAPS-1 taps, centred on input start_offset + j*DECIM_RATIO.
// Output channel (out_valid / out_stall, filtered_sample): one word per DECIM_RATIO
// inputs once warmup has passed, until output_count words have gone out.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 start_offset,
// index 1 output_count, others ignored; write only while the block is idle. A pending
// write holds in_stall high for that cycle.
// Inputs that produce no word do not hold in_stall. An input that produces a word holds
// in_stall high while one multiplier walks the HALF_TAPS tap pairs, one pair a cycle,
// and until the word is loaded into the output register; no new input enters meanwhile.
// Each pair passes the history read, product and accumulator registers.
// A stalled output word holds in its register; inputs that produce no word still
// enter, and a finished word waits until the register frees up.
// Reset empties the history, loads warmup for start_offset 0, zeroes phase and the
// word count and sets output_count to 65535; the tap table is constant.
`default_nettype none
module windowed_sinc_decimator #(
	parameter int SAMPLE_BITS = wsd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  wire logic                                beyond_end,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]            filtered_sample,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [wsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [wsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_RUN   = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t                          state_q;
	logic [wsd_pkg::TAP_W-1:0]       k_q;
	logic [wsd_pkg::WARM_W-1:0]      warm_q;
	logic [wsd_pkg::PHASE_W-1:0]     phase_q, phase_next;
	logic [wsd_pkg::COUNT_W-1:0]     output_count_q, outputs_done_q;
	logic                            accept, limit, start, cfg_wr, out_load, out_free;
	logic signed [wsd_pkg::WARM_W:0] warm_sum;
	logic [wsd_pkg::WARM_W-1:0]      warm_load;
	logic signed [SAMPLE_BITS-1:0]   wr_data, rd_a, rd_b, result;
	logic [wsd_pkg::AGE_W-1:0]       age_a, age_b;
	wsd_pkg::iter_t                  iss;
	logic                            mac_done;
	logic                            out_valid_q;
	logic signed [SAMPLE_BITS-1:0]   filtered_q;

	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign limit     = outputs_done_q >= output_count_q;
	assign start     = accept && !limit && (warm_q == '0) && (phase_q == '0);
	assign wr_data   = beyond_end ? '0 : sample;

	assign phase_next = (phase_q == wsd_pkg::PHASE_W'(wsd_pkg::DECIM_RATIO - 1)) ?
		'0 : phase_q + wsd_pkg::PHASE_W'(1);

	assign warm_sum  = $signed({cfg_data[wsd_pkg::CFG_DATA_W-1], cfg_data}) +
		$signed((wsd_pkg::WARM_W + 1)'(wsd_pkg::HALF_TAPS - 1));
	assign warm_load = warm_sum[wsd_pkg::WARM_W] ? '0 : warm_sum[wsd_pkg::WARM_W-1:0];

	assign age_a = wsd_pkg::AGE_W'(wsd_pkg::HALF_TAPS - 1) - wsd_pkg::AGE_W'(k_q);
	assign age_b = wsd_pkg::AGE_W'(wsd_pkg::HALF_TAPS - 1) + wsd_pkg::AGE_W'(k_q);

	always_comb begin
		iss.vld  = (state_q == S_RUN);
		iss.last = (k_q == wsd_pkg::TAP_W'(wsd_pkg::HALF_TAPS - 1));
		iss.tap  = k_q;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_DRAIN) && mac_done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			k_q            <= '0;
			warm_q         <= wsd_pkg::WARM_W'(wsd_pkg::HALF_TAPS - 1);
			phase_q        <= '0;
			output_count_q <= '1;
			outputs_done_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					wsd_pkg::CFG_START_OFFSET: begin
						warm_q  <= warm_load;
						phase_q <= '0;
					end
					wsd_pkg::CFG_OUTPUT_COUNT: begin
						output_count_q <= cfg_data[wsd_pkg::COUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (accept && !limit) begin
				if (warm_q != '0) begin
					warm_q <= warm_q - wsd_pkg::WARM_W'(1);
				end else begin
					phase_q <= phase_next;
					if (phase_q == '0)
						outputs_done_q <= outputs_done_q + wsd_pkg::COUNT_W'(1);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						k_q     <= '0;
					end
				end
				S_RUN: begin
					if (iss.last) state_q <= S_DRAIN;
					else k_q <= k_q + wsd_pkg::TAP_W'(1);
				end
				S_DRAIN: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) filtered_q <= result;
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = filtered_q;

	wsd_hist #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (wr_data),
		.age_a   (age_a),
		.age_b   (age_b),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);

	wsd_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (start),
		.iss    (iss),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.done   (mac_done),
		.result (result)
	);

	a_done_outside_run: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q != S_RUN))
		else $error("accumulator finished during the tap walk");

	a_no_input_before_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !$past(accept))
		else $error("history changed while a word was being computed");

	a_count_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_RUN) |-> outputs_done_q == $past(outputs_done_q) +
			wsd_pkg::COUNT_W'(1))
		else $error("output count not advanced for a started word");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && iss.last |=> (state_q == S_DRAIN) && !mac_done)
		else $error("tap walk ended out of step with the accumulator");

endmodule
`default_nettype wire

// ===== hw/rtl/wsd_hist.sv =====
// Sample history: circular memory with fill count and two registered read ports.
`default_nettype none
module wsd_hist #(
	parameter int SAMPLE_BITS = wsd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
	input  wire logic [wsd_pkg::AGE_W-1:0]     age_a,
	input  wire logic [wsd_pkg::AGE_W-1:0]     age_b,
	output logic signed [SAMPLE_BITS-1:0]      rd_a,
	output logic signed [SAMPLE_BITS-1:0]      rd_b
);

	logic signed [SAMPLE_BITS-1:0] mem [wsd_pkg::MEM_DEPTH];
	logic [wsd_pkg::AGE_W-1:0]     wp_q;
	logic [wsd_pkg::FILL_W-1:0]    fill_q;
	logic [wsd_pkg::AGE_W-1:0]     addr_a, addr_b;
	logic signed [SAMPLE_BITS-1:0] data_a_s1, data_b_s1;
	logic                          va_s1, vb_s1;

	assign addr_a = wp_q - wsd_pkg::AGE_W'(1) - age_a;
	assign addr_b = wp_q - wsd_pkg::AGE_W'(1) - age_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			va_s1  <= 1'b0;
			vb_s1  <= 1'b0;
		end else begin
			va_s1 <= wsd_pkg::FILL_W'(age_a) < fill_q;
			vb_s1 <= wsd_pkg::FILL_W'(age_b) < fill_q;
			if (wr_en) begin
				wp_q <= wp_q + wsd_pkg::AGE_W'(1);
				if (fill_q != wsd_pkg::FILL_W'(wsd_pkg::HIST_LEN))
					fill_q <= fill_q + wsd_pkg::FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wp_q] <= wr_data;
		data_a_s1 <= mem[addr_a];
		data_b_s1 <= mem[addr_b];
	end

	assign rd_a = va_s1 ? data_a_s1 : '0;
	assign rd_b = vb_s1 ? data_b_s1 : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/wsd_mac.sv =====
// Shared multiply-accumulate over tap pairs, with rounding and saturation.
`default_nettype none
module wsd_mac #(
	parameter int SAMPLE_BITS = wsd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clear,
	input  wire wsd_pkg::iter_t                iss,
	input  wire logic signed [SAMPLE_BITS-1:0] rd_a,
	input  wire logic signed [SAMPLE_BITS-1:0] rd_b,
	output logic                               done,
	output logic signed [SAMPLE_BITS-1:0]      result
);

	localparam int PAIR_W = SAMPLE_BITS + 1;
	localparam int PROD_W = PAIR_W + wsd_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + wsd_pkg::TAP_W;
	localparam int RES_W  = ACC_W + 1 - wsd_pkg::COEF_FRAC;
	localparam longint COEF_HALF = wsd_pkg::COEF_ONE / 2;

	wsd_pkg::iter_t              iter_s1, iter_s2;
	logic signed [PAIR_W-1:0]    pair;
	logic signed [SAMPLE_BITS-1:0] rd_b_m;
	wsd_pkg::coef_t              coef;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        done_q;
	logic signed [ACC_W:0]       rnd;
	logic signed [RES_W-1:0]     shifted;
	logic signed [RES_W-1:0]     smax_ext, smin_ext;

	assign rd_b_m = (iter_s1.tap == '0) ? '0 : rd_b;
	assign pair   = PAIR_W'(rd_a) + PAIR_W'(rd_b_m);
	assign coef   = wsd_pkg::COEF_TAB[iter_s1.tap];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_s1 <= '0;
			iter_s2 <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			iter_s1 <= iss;
			iter_s2 <= iter_s1;
			if (clear) begin
				acc_q  <= '0;
				done_q <= 1'b0;
			end else if (iter_s2.vld) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
				if (iter_s2.last) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * pair;
	end

	assign rnd      = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(COEF_HALF);
	assign shifted  = rnd[ACC_W:wsd_pkg::COEF_FRAC];
	assign smax_ext = {{(RES_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	assign smin_ext = ~smax_ext;

	always_comb begin
		priority if (shifted > smax_ext) result = smax_ext[SAMPLE_BITS-1:0];
		else if (shifted < smin_ext)     result = smin_ext[SAMPLE_BITS-1:0];
		else                             result = shifted[SAMPLE_BITS-1:0];
	end

	assign done = done_q;

endmodule
`default_nettype wire
